>>> rtl/core/urx_pkg.sv
// Package for the UART frame receiver: constants, phase type and shared structs.
package urx_pkg;

   // Samples per frame: data bits followed by the parity bit
   localparam int unsigned FRAME_BITS = 9;
   localparam int unsigned BIDX_W     = $clog2(FRAME_BITS + 1);
   localparam int unsigned EXT_W      = (FRAME_BITS > 9) ? FRAME_BITS : 9;

   localparam int unsigned TICK_W = 16;
   localparam int unsigned CSR_W  = 16;
   localparam int unsigned ADDR_W = 2;

   localparam logic [7:0]        PARITY_FILL     = 8'd3;
   localparam logic [TICK_W-1:0] BIT_TICKS_RST   = 16'd10;
   localparam logic [TICK_W-1:0] START_TICKS_RST = 16'd15;
   localparam logic [TICK_W-1:0] GUARD_TICKS_RST = 16'd15;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_BITS,
      PH_WAIT_HIGH,
      PH_GUARD
   } phase_type;

   typedef enum logic [ADDR_W-1:0] {
      CSR_BIT_TICKS   = 2'd0,
      CSR_START_TICKS = 2'd1,
      CSR_GUARD_TICKS = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic [TICK_W-1:0] bit_ticks;
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] guard_ticks;
   } cfg_type;

   typedef struct packed {
      logic       vld;
      logic [7:0] rx_byte;
      logic       parity_error;
   } result_type;

endpackage

>>> rtl/core/uart_frame_receiver_with_parity.sv
// Top level of the UART frame receiver: config registers, input and result registers.
//
// Usage:
//   req channel: one word per oversampling tick, req_line_level = sampled RX line
//   (1 = idle high). A word is taken at an edge with req_valid high and
//   req_stall low.
//   rsp channel: one word per received frame, rsp_rx_byte and rsp_parity_error
//   (byte forced to 3 on odd parity over the nine samples).
//   csr port: csr_write_enable, csr_index (0 bit_ticks, 1 start_ticks,
//   2 guard_ticks), csr_write_data; write only while no frame is in progress.
// Throughput: one tick word per cycle while req_stall is low.
// Path: the word that completes a frame is held in the input register, and
//   the result register loads from it once the result slot is free or
//   draining, which raises rsp_valid.
// Reset: synchronous, clears the state machine to idle, empties both
//   registers and restores tick counts 10, 15, 15.
// Stall: while rsp_stall holds a pending result, the input register keeps
//   one word and req_stall rises only once that register is also full.
module uart_frame_receiver_with_parity
   import urx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_line_level,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_rx_byte,
   output logic              rsp_parity_error,

   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_vld_ff;
   logic       in_level_ff;
   logic       out_vld_ff;
   logic [7:0] out_byte_ff;
   logic       out_perr_ff;
   logic       adv;
   logic       step;
   result_type res;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks   <= BIT_TICKS_RST;
         cfg_ff.start_ticks <= START_TICKS_RST;
         cfg_ff.guard_ticks <= GUARD_TICKS_RST;
      end else if (csr_write_enable) begin
         case (csr_addr_type'(csr_index))
            CSR_BIT_TICKS:   cfg_ff.bit_ticks   <= csr_write_data;
            CSR_START_TICKS: cfg_ff.start_ticks <= csr_write_data;
            CSR_GUARD_TICKS: cfg_ff.guard_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow: stage moves when the result slot is free or draining
   assign adv       = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && adv;
   assign req_stall = in_vld_ff && !adv;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_level_ff <= req_line_level;
   end

   urx_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (in_level_ff),
      .cfg   (cfg_ff),
      .res   (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= step && res.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.vld) begin
         out_byte_ff <= res.rx_byte;
         out_perr_ff <= res.parity_error;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_rx_byte      = out_byte_ff;
   assign rsp_parity_error = out_perr_ff;

endmodule

>>> rtl/core/urx_core.sv
// Frame state machine: advances one tick per step and flags a finished frame.
module urx_core
   import urx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       level,
   input  cfg_type    cfg,
   output result_type res
);

   phase_type                phase_ff, phase_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [BIDX_W-1:0]        bidx_ff, bidx_in;
   logic [FRAME_BITS-1:0]    shift_ff, shift_in;
   logic                     par_ff, par_in;

   logic [TICK_W-1:0]        tick_inc;
   logic [EXT_W-1:0]         shift_ext;

   assign tick_inc  = tick_ff + 1'b1;
   assign shift_ext = EXT_W'(shift_ff);

   // State registers, updated only when a tick word is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bidx_ff  <= '0;
         shift_ff <= '0;
         par_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bidx_ff  <= bidx_in;
         shift_ff <= shift_in;
         par_ff   <= par_in;
      end
   end

   // Next state and frame completion
   always_comb begin
      logic finish;
      logic high_seen;
      logic sample;
      finish    = 1'b0;
      high_seen = 1'b0;
      sample    = 1'b0;
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bidx_in   = bidx_ff;
      shift_in  = shift_ff;
      par_in    = par_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (!level) begin
               phase_in = PH_START;
               tick_in  = '0;
               bidx_in  = '0;
               shift_in = '0;
               par_in   = 1'b0;
            end
         end
         PH_START: begin
            tick_in = tick_inc;
            if (tick_inc >= cfg.start_ticks) sample = 1'b1;
         end
         PH_BITS: begin
            tick_in = tick_inc;
            if (tick_inc >= cfg.bit_ticks) begin
               if (bidx_ff < BIDX_W'(FRAME_BITS)) begin
                  sample = 1'b1;
               end else begin
                  tick_in = '0;
                  if (level) high_seen = 1'b1;
                  else phase_in = PH_WAIT_HIGH;
               end
            end
         end
         PH_WAIT_HIGH: begin
            if (level) high_seen = 1'b1;
         end
         PH_GUARD: begin
            tick_in = tick_inc;
            if (tick_inc >= cfg.guard_ticks) finish = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase

      // Shift in one sample, first received ends up on top
      if (sample) begin
         shift_in = {shift_ff[FRAME_BITS-2:0], level};
         par_in   = par_ff ^ level;
         bidx_in  = bidx_ff + 1'b1;
         tick_in  = '0;
         phase_in = PH_BITS;
      end

      // Stop level seen: start guard count or finish at once
      if (high_seen) begin
         tick_in = '0;
         if (cfg.guard_ticks == '0) finish = 1'b1;
         else phase_in = PH_GUARD;
      end

      if (finish) begin
         phase_in = PH_IDLE;
         tick_in  = '0;
      end

      res.vld          = finish;
      res.parity_error = par_ff;
      res.rx_byte      = par_ff ? PARITY_FILL : shift_ext[8:1];
   end

   // A finished frame always lands back in idle
   assert property (@(posedge clock) disable iff (reset)
      (step && res.vld) |=> (phase_ff == PH_IDLE))
      else $error("frame finished but phase not idle");

   // The sample count never runs past the frame length
   assert property (@(posedge clock) disable iff (reset)
      bidx_ff <= BIDX_W'(FRAME_BITS))
      else $error("bit index past frame length");

   // Parity failure forces the fill byte
   assert property (@(posedge clock) disable iff (reset)
      (res.vld && res.parity_error) |-> (res.rx_byte == PARITY_FILL))
      else $error("parity error without fill byte");

endmodule

>>> verif/uart_frame_receiver_with_parity_tb.sv
// Self-checking testbench for the UART frame receiver: tick-level frames, rate settings, parity.
module uart_frame_receiver_with_parity_tb;
   import urx_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int TICK_TARGET  = 1600;
   localparam int FRAME_TARGET = 40;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       parity_error;
   } frame_result_type;

   // Tracks the receiver state tick by tick and holds the frames still owed.
   class frame_scoreboard;
      logic [TICK_W-1:0]     bit_ticks;
      logic [TICK_W-1:0]     start_ticks;
      logic [TICK_W-1:0]     guard_ticks;
      phase_type             phase;
      logic [TICK_W-1:0]     tick_count;
      logic [BIDX_W-1:0]     bit_index;
      logic [FRAME_BITS-1:0] shift_bits;
      logic                  ones_parity;
      frame_result_type      pending_frames[$];
      int                    errors;
      int                    frames_predicted;
      int                    frames_checked;
      int                    parity_frames;

      function void clear();
         bit_ticks        = BIT_TICKS_RST;
         start_ticks      = START_TICKS_RST;
         guard_ticks      = GUARD_TICKS_RST;
         phase            = PH_IDLE;
         tick_count       = '0;
         bit_index        = '0;
         shift_bits       = '0;
         ones_parity      = 1'b0;
         errors           = 0;
         frames_predicted = 0;
         frames_checked   = 0;
         parity_frames    = 0;
      endfunction

      function void set_reg(csr_addr_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_BIT_TICKS:   bit_ticks   = value;
            CSR_START_TICKS: start_ticks = value;
            CSR_GUARD_TICKS: guard_ticks = value;
            default: ;
         endcase
      endfunction

      // Frame complete: odd ones count replaces the byte with the fill value
      function void emit_frame();
         frame_result_type      res;
         logic [EXT_W-1:0]      wide;
         wide = '0;
         wide[FRAME_BITS-1:0] = shift_bits;
         if (ones_parity) begin
            res.rx_byte      = PARITY_FILL;
            res.parity_error = 1'b1;
            parity_frames++;
         end else begin
            res.rx_byte      = wide[8:1];
            res.parity_error = 1'b0;
         end
         pending_frames.push_back(res);
         frames_predicted++;
         phase      = PH_IDLE;
         tick_count = '0;
      endfunction

      // Stop level seen: zero guard emits on this very tick
      function void line_high();
         tick_count = '0;
         if (guard_ticks == 0)
            emit_frame();
         else
            phase = PH_GUARD;
      endfunction

      function void take_sample(logic level);
         shift_bits  = {shift_bits[FRAME_BITS-2:0], level};
         ones_parity = ones_parity ^ level;
         bit_index++;
         tick_count  = '0;
         phase       = PH_BITS;
      endfunction

      // One accepted line word
      function void advance_line(logic level);
         case (phase)
            PH_IDLE: begin
               if (!level) begin
                  phase       = PH_START;
                  tick_count  = '0;
                  bit_index   = '0;
                  shift_bits  = '0;
                  ones_parity = 1'b0;
               end
            end
            PH_START: begin
               tick_count++;
               if (tick_count >= start_ticks)
                  take_sample(level);
            end
            PH_BITS: begin
               tick_count++;
               if (tick_count >= bit_ticks) begin
                  if (bit_index < FRAME_BITS) begin
                     take_sample(level);
                  end else begin
                     tick_count = '0;
                     if (level)
                        line_high();
                     else
                        phase = PH_WAIT_HIGH;
                  end
               end
            end
            PH_WAIT_HIGH: begin
               if (level)
                  line_high();
            end
            PH_GUARD: begin
               tick_count++;
               if (tick_count >= guard_ticks)
                  emit_frame();
            end
            default: begin
               phase      = PH_IDLE;
               tick_count = '0;
            end
         endcase
      endfunction

      function void check_frame(logic [7:0] rx_byte, logic parity_error);
         frame_result_type want;
         if (pending_frames.size() == 0) begin
            $error("frame word with none pending: rx_byte %02h parity_error %0b",
                   rx_byte, parity_error);
            errors++;
            return;
         end
         want = pending_frames.pop_front();
         frames_checked++;
         if (rx_byte !== want.rx_byte) begin
            $error("rx_byte: expected %02h, got %02h", want.rx_byte, rx_byte);
            errors++;
         end
         if (parity_error !== want.parity_error) begin
            $error("parity_error: expected %0b, got %0b", want.parity_error, parity_error);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_line_level;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_rx_byte;
   logic              rsp_parity_error;
   logic              csr_write_enable;
   logic [ADDR_W-1:0] csr_index;
   logic [CSR_W-1:0]  csr_write_data;

   frame_scoreboard sb = new;
   int  ticks_sent;
   int  settings_used;
   int  calm_left;
   bit  no_idle;

   uart_frame_receiver_with_parity dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_level   (req_line_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_parity_error (rsp_parity_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Result side back-pressure, with quiet stretches
   initial begin
      int len;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         len = pick_gap();
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 99) < 4)
            repeat ($urandom_range(100, 300)) @(negedge clock);
         else
            repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Frame word monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_frame(rsp_rx_byte, rsp_parity_error);
   end

   // Watchdog: ends the run when no word moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("uart_frame_receiver_with_parity: mismatch");
      $finish;
   end

   // Drives one line word; called and returns at a falling edge
   task automatic send_tick(input logic level);
      int gap;
      gap = 0;
      if (!no_idle) begin
         if (calm_left > 0)
            calm_left--;
         else if ($urandom_range(0, 99) < 3)
            calm_left = $urandom_range(50, 200);
         else
            gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_line_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.advance_line(level);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_addr_type idx, input logic [CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic program_rates(input logic [CSR_W-1:0] bit_t, input logic [CSR_W-1:0] start_t,
                                input logic [CSR_W-1:0] guard_t);
      write_reg(CSR_BIT_TICKS, bit_t);
      write_reg(CSR_START_TICKS, start_t);
      write_reg(CSR_GUARD_TICKS, guard_t);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Hold the line high until the receiver is idle and every frame is back
   task automatic settle();
      while (sb.phase != PH_IDLE) send_tick(1'b1);
      req_valid <= 1'b0;
      while (sb.pending_frames.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One frame laid out at the programmed rates, data MSB first then parity
   task automatic send_frame(input logic [7:0] data, input logic par, input int stop_low,
                             input bit noisy_guard, input bit glitch);
      logic [8:0] bits;
      logic       lvl;
      bits = {data, par};
      for (int i = 0; i < int'(sb.start_ticks); i++) send_tick(1'b0);
      for (int k = 0; k < 9; k++) begin
         for (int i = 0; i < int'(sb.bit_ticks); i++) begin
            lvl = bits[8-k];
            // short spikes away from the sample point
            if (glitch && i > 0 && $urandom_range(0, 7) == 0) lvl = ~lvl;
            send_tick(lvl);
         end
      end
      repeat (stop_low) send_tick(1'b0);
      send_tick(1'b1);
      for (int i = 0; i < int'(sb.guard_ticks); i++)
         send_tick(noisy_guard ? 1'($urandom_range(0, 1)) : 1'b1);
   endtask

   // Mostly well-formed frames, some noise bursts that break framing
   task automatic send_random_traffic();
      logic [7:0] data;
      logic       par;
      if ($urandom_range(0, 99) < 80) begin
         data = 8'($urandom_range(0, 255));
         par  = ^data;
         if ($urandom_range(0, 99) < 30) par = ~par;
         send_frame(data, par,
                    ($urandom_range(0, 99) < 25) ? $urandom_range(1, 5) : 0,
                    $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 15);
         repeat ($urandom_range(0, 4)) send_tick(1'b1);
      end else begin
         repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int r;
      int bit_t;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_line_level   = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BIT_TICKS;
      csr_write_data   = '0;
      ticks_sent       = 0;
      settings_used    = 0;
      calm_left        = 0;
      no_idle          = 1'b0;
      sb.clear();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Fastest rates: all-ones byte with zero guard, then zero byte with bad parity
      // and a late stop bit
      program_rates(16'd1, 16'd1, 16'd0);
      send_frame(8'hFF, 1'b0, 0, 1'b0, 1'b0);
      send_frame(8'h00, 1'b1, 2, 1'b0, 1'b0);
      settle();

      // Power-on rates
      program_rates(BIT_TICKS_RST, START_TICKS_RST, GUARD_TICKS_RST);
      repeat (3) send_random_traffic();
      settle();

      // Random rate settings, small so that frames stay short
      while (ticks_sent < TICK_TARGET || sb.frames_predicted < FRAME_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            program_rates(16'd1, 16'd1, 16'd0);
         end else if (r < 30) begin
            program_rates(16'd1, 16'($urandom_range(1, 3)), 16'($urandom_range(0, 2)));
         end else begin
            bit_t = $urandom_range(1, 5);
            program_rates(16'(bit_t), 16'($urandom_range(1, 2 * bit_t + 3)),
                          16'($urandom_range(0, 12)));
         end
         repeat ($urandom_range(2, 8)) send_random_traffic();
         settle();
      end

      // Moderate rates: one full frame, sent back to back
      program_rates(16'd6, 16'd9, 16'd7);
      no_idle = 1'b1;
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 1'b0, 1'b0);
      no_idle = 1'b0;
      settle();
      repeat (16) @(negedge clock);

      $display("%0d line ticks over %0d rate settings; %0d frames checked, %0d with bad parity",
               ticks_sent, settings_used, sb.frames_checked, sb.parity_frames);
      if (sb.errors == 0 && sb.pending_frames.size() == 0)
         $display("uart_frame_receiver_with_parity: match");
      else
         $display("uart_frame_receiver_with_parity: mismatch");
      $finish;
   end

endmodule
